### rtl/nnr_pkg.sv
// Package for the name-to-node registry: sizes, request codes, RAM port struct
// and the key normalization function.
// No dependencies; used by every other file of the block.
package nnr_pkg;

   // Table geometry
   localparam int SLOTS       = 16;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W       = $clog2(SLOTS + 1);
   localparam int NAME_BYTES  = 8;
   localparam int SERVER_SLOT = 0;
   localparam int NODE_W      = 8;
   localparam int KEY_W       = 64;
   localparam int KIND_W      = 2;

   // "/io0" packed with the first character in the low byte
   localparam logic [KEY_W-1:0] SERVER_NAME = 64'h0000_0000_306F_692F;

   // Request codes
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LINK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_UNLINK = 2'd2;

   // Controller to slot RAM
   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [KEY_W-1:0]  wr_data;
   } ram_req_type;

   // Cut a key at its first zero byte and after NAME_BYTES bytes
   function automatic logic [KEY_W-1:0] norm_key(logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      logic             live;
      r    = '0;
      live = 1'b1;
      for (int b = 0; b < KEY_W / 8; b++) begin
         if (k[8*b +: 8] == 8'h00 || b >= NAME_BYTES) live = 1'b0;
         if (live) r[8*b +: 8] = k[8*b +: 8];
      end
      return r;
   endfunction

endpackage

### rtl/nnr_if.sv
// Valid/ready channel interfaces for the registry: request and response.
// Depends on nnr_pkg for field widths.
interface nnr_req_if;
   logic                           valid;
   logic                           ready;
   logic [nnr_pkg::KIND_W-1:0]     kind;
   logic [nnr_pkg::NODE_W-1:0]     node;
   logic [nnr_pkg::KEY_W-1:0]      name_key;

   modport source (output valid, kind, node, name_key, input ready);
   modport sink   (input valid, kind, node, name_key, output ready);
endinterface

interface nnr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           status;
   logic [nnr_pkg::NODE_W-1:0]     found_node;

   modport source (output valid, status, found_node, input ready);
   modport sink   (input valid, status, found_node, output ready);
endinterface

### rtl/nnr_slot_ram.sv
// Slot name memory: one write and one registered read per cycle.
// Per-entry valid bits give the reset contents (empty, server slot "/io0").
// Depends on nnr_pkg.
module nnr_slot_ram (
   input  logic                          clock,
   input  logic                          reset,
   input  nnr_pkg::ram_req_type          ram_req,
   output logic [nnr_pkg::KEY_W-1:0]     rd_data
);

   logic [nnr_pkg::KEY_W-1:0]  mem [nnr_pkg::SLOTS];
   logic [nnr_pkg::SLOTS-1:0]  vld_ff;
   logic [nnr_pkg::KEY_W-1:0]  rd_raw_ff;
   logic                       rd_vld_ff;
   logic [nnr_pkg::SLOT_W-1:0] rd_addr_ff;

   // Storage array
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) mem[ram_req.wr_addr] <= ram_req.wr_data;
      if (ram_req.rd_en) begin
         rd_raw_ff  <= mem[ram_req.rd_addr];
         rd_addr_ff <= ram_req.rd_addr;
      end
   end

   // Written-since-reset flags
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ram_req.wr_en) vld_ff[ram_req.wr_addr] <= 1'b1;
         if (ram_req.rd_en) rd_vld_ff <= vld_ff[ram_req.rd_addr];
      end
   end

   // Unwritten entries read as their reset value
   always_comb begin
      if (rd_vld_ff) begin
         rd_data = rd_raw_ff;
      end else if (int'(rd_addr_ff) == nnr_pkg::SERVER_SLOT) begin
         rd_data = nnr_pkg::SERVER_NAME;
      end else begin
         rd_data = '0;
      end
   end

endmodule

### rtl/nnr_ctrl.sv
// Request sequencer: scans the slot RAM for the key, reads the link target,
// then decides, writes back and loads the response register.
// Depends on nnr_pkg and nnr_if.
module nnr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   nnr_req_if.sink                       req_bus,
   nnr_rsp_if.source                     rsp_bus,
   output nnr_pkg::ram_req_type          ram_req,
   input  logic [nnr_pkg::KEY_W-1:0]     rd_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_NODE = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type                   state_ff, state_in;
   logic [nnr_pkg::KIND_W-1:0]  kind_ff;
   logic [nnr_pkg::NODE_W-1:0]  node_ff;
   logic [nnr_pkg::KEY_W-1:0]   key_ff;
   logic [nnr_pkg::CNT_W-1:0]   issue_cnt_ff, issue_cnt_in;
   logic                        cmp_vld_ff, cmp_vld_in;
   logic [nnr_pkg::SLOT_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic                        hit_ff, hit_in;
   logic [nnr_pkg::SLOT_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [nnr_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        status_ff, status_in;
   logic [nnr_pkg::NODE_W-1:0]  found_ff, found_in;

   logic accept, issue, match_now, out_free, node_ok, ok;

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign accept             = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.found_node = found_ff;
   assign out_free           = !rsp_valid_ff || rsp_bus.ready;

   // Scan pipeline: issue one address per cycle, compare in the next cycle
   assign match_now = (state_ff == ST_SCAN) && cmp_vld_ff && (rd_data == key_ff);
   assign issue     = (state_ff == ST_SCAN) && !match_now &&
                      (issue_cnt_ff < nnr_pkg::CNT_W'(nnr_pkg::SLOTS));
   assign node_ok   = ({1'b0, node_ff} < (nnr_pkg::NODE_W + 1)'(nnr_pkg::SLOTS));

   // Next-state and datapath
   always_comb begin
      state_in     = state_ff;
      issue_cnt_in = issue_cnt_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      found_in     = found_ff;
      ok           = 1'b0;
      ram_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_bus.kind inside {nnr_pkg::KIND_LOOKUP, nnr_pkg::KIND_LINK,
                                               nnr_pkg::KIND_UNLINK}) begin
               state_in     = ST_SCAN;
               issue_cnt_in = '0;
               hit_in       = 1'b0;
               hit_idx_in   = '0;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = issue_cnt_ff[nnr_pkg::SLOT_W-1:0];
               issue_cnt_in    = issue_cnt_ff + 1'b1;
               cmp_vld_in      = 1'b1;
               cmp_idx_in      = issue_cnt_ff[nnr_pkg::SLOT_W-1:0];
            end
            if (match_now) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
               state_in   = ST_NODE;
            end else if (!issue && !cmp_vld_ff) begin
               state_in = ST_NODE;
            end
         end
         ST_NODE: begin
            // Fetch the link target's slot
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = node_ff[nnr_pkg::SLOT_W-1:0];
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            case (kind_ff)
               nnr_pkg::KIND_LINK: begin
                  ok = (count_ff < nnr_pkg::CNT_W'(nnr_pkg::SLOTS)) && !hit_ff &&
                       node_ok && (rd_data == '0);
                  ram_req.wr_addr = node_ff[nnr_pkg::SLOT_W-1:0];
                  ram_req.wr_data = key_ff;
               end
               nnr_pkg::KIND_UNLINK: begin
                  ok = (count_ff != '0) && hit_ff;
                  ram_req.wr_addr = hit_idx_ff;
                  ram_req.wr_data = '0;
               end
               default: ok = hit_ff;
            endcase
            if (out_free) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               status_in     = !ok;
               found_in      = (kind_ff == nnr_pkg::KIND_LOOKUP && hit_ff) ?
                               nnr_pkg::NODE_W'(hit_idx_ff) : '0;
               if (ok && kind_ff != nnr_pkg::KIND_LOOKUP) begin
                  ram_req.wr_en = 1'b1;
                  count_in      = (kind_ff == nnr_pkg::KIND_LINK) ? count_ff + 1'b1
                                                                  : count_ff - 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         hit_ff       <= hit_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_bus.kind;
         node_ff <= req_bus.node;
         key_ff  <= nnr_pkg::norm_key(req_bus.name_key);
      end
      issue_cnt_ff <= issue_cnt_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_idx_ff   <= hit_idx_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
   end

endmodule

### rtl/name_to_node_registry_top.sv
// Top level of the name-to-node registry.
// Depends on nnr_pkg, nnr_if, nnr_slot_ram and nnr_ctrl.
//
// Channels: req_bus carries one request beat (kind, node, name_key); kind 0
// looks a name up, 1 links it to a node's slot, 2 unlinks it, 3 is dropped
// without a response. rsp_bus returns one beat per request: status (0 ok or
// found, 1 failed or not found) and found_node for a successful lookup.
// Keys are cut at their first zero byte before use.
//
// Sequence: the slot RAM has one read port, so the scan reads one slot a cycle
// and stops at the first match; a miss reads all 16 slots. Then ST_NODE reads
// the link target slot and ST_DONE decides, writes back and loads the response
// register. One request is in work at a time; the next is taken once the
// sequencer is back in idle.
//
// Reset: all slots empty except slot 0 holding "/io0", count zero. No
// clearing pass is needed; per-slot valid bits supply the reset contents.
// Stall: a response waits in its output register while rsp_bus.ready is low;
// a new request may still be taken and run until its own response is due.
module name_to_node_registry_top (
   input  logic        clock,
   input  logic        reset,
   nnr_req_if.sink     req_bus,
   nnr_rsp_if.source   rsp_bus
);

   nnr_pkg::ram_req_type          ram_req;
   logic [nnr_pkg::KEY_W-1:0]     rd_data;

   // Sequencer
   nnr_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // Slot name storage
   nnr_slot_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule

### tb/sv/tb_name_to_node_registry_top.sv
// Self-checking testbench for name_to_node_registry_top: directed and random
// lookup, link and unlink requests against a behavioral model of the slot table.
// Depends on nnr_pkg, nnr_if and the RTL of the registry.
`timescale 1ns / 1ps

module tb_name_to_node_registry_top;

   localparam logic [nnr_pkg::KIND_W-1:0] KIND_RESERVED = 2'd3;
   localparam int RANDOM_REQS    = 500;
   localparam int IDLE_LIMIT     = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int HOLDOFF_AT_RSP = 60;
   localparam int POOL_SIZE      = 20;

   typedef struct packed {
      logic [nnr_pkg::KIND_W-1:0] kind;
      logic [nnr_pkg::NODE_W-1:0] node;
      logic [nnr_pkg::KEY_W-1:0]  name_key;
   } registry_req_type;

   typedef struct packed {
      logic                       status;
      logic [nnr_pkg::NODE_W-1:0] found_node;
   } registry_reply_type;

   logic clock;
   logic reset;

   nnr_req_if req_bus();
   nnr_rsp_if rsp_bus();

   name_to_node_registry_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow of the slot table and of the registration count
   logic [nnr_pkg::KEY_W-1:0] slot_shadow [nnr_pkg::SLOTS];
   logic [nnr_pkg::CNT_W-1:0] linked_count;

   registry_req_type   req_pending  [$];
   registry_reply_type replies_due  [$];
   logic [nnr_pkg::KEY_W-1:0] name_pool [POOL_SIZE];

   int   req_total;
   int   req_taken;
   int   rsp_seen;
   int   fail_count;
   int   req_gap;
   int   rsp_stall;
   int   holdoff_left;
   bit   holdoff_used;
   bit   req_fire;
   int   idle_cycles;
   int   cycle_count;

   // Alternate between stretches with and without idling on both channels
   wire  calm = (cycle_count % 1500) < 400;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Name as the block sees it: up to the first zero byte, at most NAME_BYTES
   function automatic logic [nnr_pkg::KEY_W-1:0] clip_name(logic [nnr_pkg::KEY_W-1:0] raw);
      logic [nnr_pkg::KEY_W-1:0] kept;
      kept = '0;
      for (int i = 0; i < nnr_pkg::NAME_BYTES && i < nnr_pkg::KEY_W / 8; i++) begin
         if (raw[8*i +: 8] == 8'h00) break;
         kept[8*i +: 8] = raw[8*i +: 8];
      end
      return kept;
   endfunction

   // Put random junk after the terminator of a short name
   function automatic logic [nnr_pkg::KEY_W-1:0] pad_junk(logic [nnr_pkg::KEY_W-1:0] clean);
      logic [nnr_pkg::KEY_W-1:0] junk;
      int n;
      n = 0;
      while (n < nnr_pkg::KEY_W / 8 && clean[8*n +: 8] != 8'h00) n++;
      if (n >= nnr_pkg::KEY_W / 8 - 1) return clean;
      junk = {$urandom, $urandom};
      for (int i = 0; i <= n; i++) junk[8*i +: 8] = 8'h00;
      return junk | clean;
   endfunction

   // Apply one request to the shadow table; returns 0 when no reply is due
   function automatic bit registry_apply(input registry_req_type rq,
                                         output registry_reply_type rp);
      logic [nnr_pkg::KEY_W-1:0] key;
      int hit;
      key = clip_name(rq.name_key);
      rp.status = 1'b1;
      rp.found_node = '0;
      hit = nnr_pkg::SLOTS;
      for (int i = nnr_pkg::SLOTS - 1; i >= 0; i--) begin
         if (slot_shadow[i] == key) hit = i;
      end
      case (rq.kind)
         nnr_pkg::KIND_LOOKUP: begin
            if (hit < nnr_pkg::SLOTS) begin
               rp.status = 1'b0;
               rp.found_node = nnr_pkg::NODE_W'(hit);
            end
         end
         nnr_pkg::KIND_LINK: begin
            if (linked_count < nnr_pkg::SLOTS && hit == nnr_pkg::SLOTS &&
                rq.node < nnr_pkg::SLOTS &&
                slot_shadow[rq.node[nnr_pkg::SLOT_W-1:0]] == '0) begin
               slot_shadow[rq.node[nnr_pkg::SLOT_W-1:0]] = key;
               linked_count = linked_count + 1'b1;
               rp.status = 1'b0;
            end
         end
         nnr_pkg::KIND_UNLINK: begin
            if (linked_count != 0 && hit < nnr_pkg::SLOTS) begin
               slot_shadow[hit] = '0;
               linked_count = linked_count - 1'b1;
               rp.status = 1'b0;
            end
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // Mostly short gaps, a few long ones, none in calm stretches
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic add_req(logic [nnr_pkg::KIND_W-1:0] kind, logic [nnr_pkg::NODE_W-1:0] node,
                          logic [nnr_pkg::KEY_W-1:0] key);
      registry_req_type rq;
      rq.kind = kind;
      rq.node = node;
      rq.name_key = key;
      req_pending.push_back(rq);
   endtask

   // Request side: take a beat, predict its reply
   always @(posedge clock) begin : req_track
      registry_reply_type rp;
      registry_req_type rq;
      req_fire <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         rq.kind = req_bus.kind;
         rq.node = req_bus.node;
         rq.name_key = req_bus.name_key;
         if (registry_apply(rq, rp)) replies_due.push_back(rp);
         req_taken <= req_taken + 1;
      end
   end

   // Request driver: next item from the pending queue after a random gap
   always @(negedge clock) begin : req_drive
      registry_req_type rq;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (req_pending.size() != 0) begin
            rq = req_pending.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.kind <= rq.kind;
            req_bus.node <= rq.node;
            req_bus.name_key <= rq.name_key;
            req_gap <= pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (!holdoff_used && rsp_seen >= HOLDOFF_AT_RSP) begin
         holdoff_used <= 1'b1;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0 && pick_gap() > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= pick_gap();
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Response check against the oldest predicted reply
   always @(posedge clock) begin : rsp_check
      registry_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_seen <= rsp_seen + 1;
         if (replies_due.size() == 0) begin
            $error("unexpected response beat: status %0d found_node %0d",
                   rsp_bus.status, rsp_bus.found_node);
            fail_count++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               fail_count++;
            end
            if (rsp_bus.found_node !== want.found_node) begin
               $error("found_node: expected %0d, got %0d",
                      want.found_node, rsp_bus.found_node);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: cycles without any beat on either channel
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin : main
      logic [nnr_pkg::KIND_W-1:0] kind;
      logic [nnr_pkg::NODE_W-1:0] node;
      logic [nnr_pkg::KEY_W-1:0]  key;
      logic [nnr_pkg::KEY_W-1:0]  nm;
      int len;
      int mode;
      int roll;
      int counted;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = '0;
      req_bus.node = '0;
      req_bus.name_key = '0;
      rsp_bus.ready = 1'b0;
      req_fire = 1'b0;
      req_taken = 0;
      rsp_seen = 0;
      fail_count = 0;
      req_gap = 0;
      rsp_stall = 0;
      holdoff_left = 0;
      holdoff_used = 1'b0;
      idle_cycles = 0;
      cycle_count = 0;

      // Table after reset: only the server slot is taken, count zero
      for (int i = 0; i < nnr_pkg::SLOTS; i++) slot_shadow[i] = '0;
      if (nnr_pkg::SERVER_SLOT < nnr_pkg::SLOTS)
         slot_shadow[nnr_pkg::SERVER_SLOT] = nnr_pkg::SERVER_NAME;
      linked_count = '0;

      // Directed: failures, empty name, junk after terminator, server entry
      add_req(nnr_pkg::KIND_UNLINK, 8'd0, nnr_pkg::SERVER_NAME);    // count still zero
      add_req(nnr_pkg::KIND_LOOKUP, 8'd77, nnr_pkg::SERVER_NAME);
      add_req(nnr_pkg::KIND_LOOKUP, 8'd0, '0);                      // first free slot
      add_req(nnr_pkg::KIND_LOOKUP, 8'd0, 64'hFFFF_FFFF_FFFF_FF00); // empty after trim
      add_req(nnr_pkg::KIND_LINK, 8'd1, '0);                        // empty name taken
      add_req(nnr_pkg::KIND_LINK, 8'd16, 64'h0000_0000_0000_6261);  // node out of range
      add_req(nnr_pkg::KIND_LINK, 8'd255, 64'h0000_0000_0000_6261);
      add_req(nnr_pkg::KIND_LINK, 8'd0, 64'h0000_0000_0000_6261);   // slot occupied
      add_req(nnr_pkg::KIND_LINK, 8'd15, 64'hFFFF_FFFF_FFFF_FFFF);
      add_req(nnr_pkg::KIND_LINK, 8'd2, 64'hDEAD_BEEF_0063_6261);   // "abc" plus junk
      add_req(nnr_pkg::KIND_LINK, 8'd4, 64'h0000_0000_0063_6261);   // already present
      add_req(nnr_pkg::KIND_LOOKUP, 8'd0, 64'h0000_0000_0063_6261);
      add_req(nnr_pkg::KIND_LOOKUP, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      add_req(nnr_pkg::KIND_LOOKUP, 8'd0, 64'h0000_0000_0000_6261); // not found
      add_req(KIND_RESERVED, 8'hA5, 64'h0123_4567_89AB_CDEF);       // dropped, no reply
      add_req(nnr_pkg::KIND_UNLINK, 8'd0, nnr_pkg::SERVER_NAME);
      add_req(nnr_pkg::KIND_LOOKUP, 8'd0, '0);
      add_req(nnr_pkg::KIND_UNLINK, 8'd0, 64'h0000_0000_0000_7A7A); // absent name
      add_req(nnr_pkg::KIND_UNLINK, 8'd0, '0);                      // frees a free slot
      add_req(nnr_pkg::KIND_UNLINK, 8'd0, 64'h0000_0000_0063_6261); // count back at zero
      add_req(nnr_pkg::KIND_LINK, 8'd0, nnr_pkg::SERVER_NAME);

      // Name pool so that random requests hit and miss existing entries
      name_pool[0] = nnr_pkg::SERVER_NAME;
      name_pool[1] = '0;
      for (int p = 2; p < POOL_SIZE; p++) begin
         len = $urandom_range(1, 8);
         nm = '0;
         for (int b = 0; b < len; b++) nm[8*b +: 8] = 8'($urandom_range(1, 255));
         name_pool[p] = nm;
      end

      // Random: phases biased toward filling, draining or a mix
      counted = 0;
      mode = 0;
      while (counted < RANDOM_REQS) begin
         if (counted % 40 == 0) mode = $urandom_range(0, 2);
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            add_req(KIND_RESERVED, nnr_pkg::NODE_W'($urandom_range(0, 255)),
                    {$urandom, $urandom});
            counted++;
            continue;
         end
         roll = $urandom_range(0, 99);
         case (mode)
            0:       kind = (roll < 60) ? nnr_pkg::KIND_LINK :
                            (roll < 85) ? nnr_pkg::KIND_LOOKUP : nnr_pkg::KIND_UNLINK;
            1:       kind = (roll < 55) ? nnr_pkg::KIND_UNLINK :
                            (roll < 80) ? nnr_pkg::KIND_LOOKUP : nnr_pkg::KIND_LINK;
            default: kind = (roll < 34) ? nnr_pkg::KIND_LINK :
                            (roll < 67) ? nnr_pkg::KIND_LOOKUP : nnr_pkg::KIND_UNLINK;
         endcase
         node = ($urandom_range(0, 99) < 85) ?
                nnr_pkg::NODE_W'($urandom_range(0, nnr_pkg::SLOTS - 1)) :
                nnr_pkg::NODE_W'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < 8) key = {$urandom, $urandom};
         else key = name_pool[$urandom_range(0, POOL_SIZE - 1)];
         if ($urandom_range(0, 99) < 30) key = pad_junk(key);
         add_req(kind, node, key);
         counted++;
      end
      req_total = req_pending.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (req_taken < req_total || replies_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
